### design/touch_gesture_recognizer_unit_assert.svh
// assertion macros for the touch gesture recognizer checker
`ifndef TOUCH_GESTURE_RECOGNIZER_UNIT_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TGR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgr assertion failed");

// next-cycle implication, disabled in reset
`define TGR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgr assertion failed");

`endif

### design/tgr_pkg.sv
// shared types and constants of the touch gesture recognizer
`timescale 1ns / 1ps

package tgr_pkg;

    localparam int TOUCH_W    = 8;
    localparam int TICK_W     = 8;
    localparam int KIND_W     = 3;
    localparam int OUT_CHAN_W = 3;
    localparam int PEND_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [TICK_W-1:0] TICK_MAX    = 8'hFF;
    localparam logic [TICK_W:0]   SWIPE_SLACK = 9'd2;

    localparam logic [TICK_W-1:0] HOLD_MIN_RESET  = 8'd50;
    localparam logic [TICK_W-1:0] TAP_MAX_RESET   = 8'd20;
    localparam logic [TICK_W-1:0] SWIPE_MAX_RESET = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MAX = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE        = 3'd0,
        EV_TAP         = 3'd1,
        EV_HOLD        = 3'd2,
        EV_SWIPE_RIGHT = 3'd3,
        EV_SWIPE_LEFT  = 3'd4
    } event_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_HELD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] hold_min;
        logic [TICK_W-1:0] tap_max;
        logic [TICK_W-1:0] swipe_max;
    } cfg_t;

    typedef struct packed {
        event_kind_t           kind;
        logic [OUT_CHAN_W-1:0] chan;
    } ring_entry_t;

    typedef struct packed {
        logic        valid;
        ring_entry_t entry;
    } push_t;

endpackage

### design/tgr_in_if.sv
// input channel: operation and touch mask
`timescale 1ns / 1ps

interface tgr_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [tgr_pkg::TOUCH_W-1:0]  touch_mask;

    modport source (output valid, output operation, output touch_mask, input ready);
    modport sink   (input valid, input operation, input touch_mask, output ready);
endinterface

### design/tgr_out_if.sv
// output channel: event result of each transaction
`timescale 1ns / 1ps

interface tgr_out_if;
    logic                            valid;
    logic                            ready;
    logic                            event_valid;
    logic [tgr_pkg::KIND_W-1:0]      event_kind;
    logic [tgr_pkg::OUT_CHAN_W-1:0]  event_channel;
    logic [tgr_pkg::PEND_W-1:0]      pending_events;

    modport source (output valid, output event_valid, output event_kind,
                    output event_channel, output pending_events, input ready);
    modport sink   (input valid, input event_valid, input event_kind,
                    input event_channel, input pending_events, output ready);
endinterface

### design/tgr_ring.sv
// event ring: overwrite-oldest queue held in a small memory
`timescale 1ns / 1ps

module tgr_ring #(
    parameter int RING_DEPTH = 4,
    parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgr_pkg::push_t       push,
    input  logic                 pop,
    output tgr_pkg::ring_entry_t rd_data,
    output logic [CNT_W-1:0]     count
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    tgr_pkg::ring_entry_t mem [RING_DEPTH];
    tgr_pkg::ring_entry_t rd_data_reg;

    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (push.valid)
        begin
            wr_ptr_reg <= wr_ptr_inc;
            // full: drop the oldest entry
            if (count_reg == CNT_FULL)
            begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
        else if (pop && (count_reg != '0))
        begin
            rd_ptr_reg <= rd_ptr_inc;
            count_reg  <= count_reg - 1'b1;
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

### design/tgr_scan.sv
// channel scan sequencer: one channel state machine step per cycle
`timescale 1ns / 1ps

module tgr_scan #(
    parameter int CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tgr_pkg::TOUCH_W-1:0]     mask,
    input  tgr_pkg::cfg_t                   cfg,
    output tgr_pkg::push_t                  push,
    output logic                            done
);

    localparam int CH_W       = $clog2(CHANNELS);
    localparam int MASK_IDX_W = $clog2(tgr_pkg::TOUCH_W);
    localparam logic [CH_W-1:0] IDX_LAST = CH_W'(CHANNELS - 1);

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_SCAN,
        SC_EXPIRE
    } scan_state_t;

    scan_state_t                      state_reg;
    logic [CH_W-1:0]                  idx_reg;
    logic [tgr_pkg::TOUCH_W-1:0]      mask_reg;
    tgr_pkg::phase_t                  phase_reg [CHANNELS];
    logic [tgr_pkg::TICK_W-1:0]       ticks_reg [CHANNELS];
    logic [CH_W-1:0]                  sw_chan_reg;
    logic [tgr_pkg::TICK_W-1:0]       sw_ticks_reg;
    logic                             sw_track_reg;

    logic [CHANNELS-1:0]              act_vec;
    logic                             act;
    tgr_pkg::phase_t                  ph;
    logic [tgr_pkg::TICK_W-1:0]       t;
    logic [tgr_pkg::TICK_W-1:0]       t_inc;
    tgr_pkg::phase_t                  ph_next;
    logic [tgr_pkg::TICK_W-1:0]       t_next;
    logic                             sw_restart;
    logic                             is_right;
    logic                             is_left;
    logic [CH_W+2:0]                  idx_wide;
    logic [CH_W+2:0]                  sw_wide;
    tgr_pkg::push_t                   push_c;
    logic                             expire;

    // channels with no mask bit read as untouched
    always_comb
    begin
        act_vec = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (i < tgr_pkg::TOUCH_W)
            begin
                act_vec[i] = mask_reg[i[MASK_IDX_W-1:0]];
            end
        end
    end

    assign act   = act_vec[idx_reg];
    assign ph    = phase_reg[idx_reg];
    assign t     = ticks_reg[idx_reg];
    assign t_inc = (t < tgr_pkg::TICK_MAX) ? t + 1'b1 : t;

    assign is_right = ((CH_W + 1)'(sw_chan_reg) + (CH_W + 1)'(1)) == (CH_W + 1)'(idx_reg);
    assign is_left  = ((CH_W + 1)'(idx_reg) + (CH_W + 1)'(1)) == (CH_W + 1)'(sw_chan_reg);
    assign idx_wide = (CH_W + 3)'(idx_reg);
    assign sw_wide  = (CH_W + 3)'(sw_chan_reg);

    always_comb
    begin
        ph_next    = ph;
        t_next     = t;
        sw_restart = 1'b0;
        push_c     = '0;
        case (ph)
            tgr_pkg::PH_IDLE:
            begin
                if (act)
                begin
                    ph_next    = tgr_pkg::PH_DOWN;
                    t_next     = '0;
                    sw_restart = 1'b1;
                    if (sw_track_reg && (sw_ticks_reg <= cfg.swipe_max))
                    begin
                        if (is_right)
                        begin
                            push_c.valid      = 1'b1;
                            push_c.entry.kind = tgr_pkg::EV_SWIPE_RIGHT;
                            push_c.entry.chan = sw_wide[tgr_pkg::OUT_CHAN_W-1:0];
                        end
                        else if (is_left)
                        begin
                            push_c.valid      = 1'b1;
                            push_c.entry.kind = tgr_pkg::EV_SWIPE_LEFT;
                            push_c.entry.chan = idx_wide[tgr_pkg::OUT_CHAN_W-1:0];
                        end
                    end
                end
            end
            tgr_pkg::PH_DOWN:
            begin
                if (act)
                begin
                    t_next = t_inc;
                    if (t_inc >= cfg.hold_min)
                    begin
                        push_c.valid      = 1'b1;
                        push_c.entry.kind = tgr_pkg::EV_HOLD;
                        push_c.entry.chan = idx_wide[tgr_pkg::OUT_CHAN_W-1:0];
                        ph_next           = tgr_pkg::PH_HELD;
                    end
                end
                else
                begin
                    if (t <= cfg.tap_max)
                    begin
                        push_c.valid      = 1'b1;
                        push_c.entry.kind = tgr_pkg::EV_TAP;
                        push_c.entry.chan = idx_wide[tgr_pkg::OUT_CHAN_W-1:0];
                    end
                    ph_next = tgr_pkg::PH_IDLE;
                end
            end
            default:
            begin
                if (!act)
                begin
                    ph_next = tgr_pkg::PH_IDLE;
                end
            end
        endcase
    end

    // window closes once the timer passes the window plus slack, at 9 bits
    assign expire = sw_track_reg &&
                    ({1'b0, sw_ticks_reg} > ({1'b0, cfg.swipe_max} + tgr_pkg::SWIPE_SLACK));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SC_IDLE;
            idx_reg      <= '0;
            mask_reg     <= '0;
            sw_chan_reg  <= '0;
            sw_ticks_reg <= '0;
            sw_track_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                phase_reg[i] <= tgr_pkg::PH_IDLE;
                ticks_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                SC_IDLE:
                begin
                    if (start)
                    begin
                        mask_reg <= mask;
                        idx_reg  <= '0;
                        if (sw_track_reg && (sw_ticks_reg < tgr_pkg::TICK_MAX))
                        begin
                            sw_ticks_reg <= sw_ticks_reg + 1'b1;
                        end
                        state_reg <= SC_SCAN;
                    end
                end
                SC_SCAN:
                begin
                    phase_reg[idx_reg] <= ph_next;
                    ticks_reg[idx_reg] <= t_next;
                    if (sw_restart)
                    begin
                        sw_chan_reg  <= idx_reg;
                        sw_ticks_reg <= '0;
                        sw_track_reg <= 1'b1;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_reg <= SC_EXPIRE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                SC_EXPIRE:
                begin
                    if (expire)
                    begin
                        sw_track_reg <= 1'b0;
                    end
                    state_reg <= SC_IDLE;
                end
                default:
                begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

    assign push = (state_reg == SC_SCAN) ? push_c : '0;
    assign done = (state_reg == SC_EXPIRE);

endmodule

### design/touch_gesture_recognizer_unit.sv
// touch gesture recognizer top level: sequencer, config registers and output register
// a tick transaction steps one channel per cycle through the shared channel step unit,
// then the expire state and the done state; a read transaction pops the ring
// (registered ring read), then the done state. the done state waits for a free output
// register; results wait there while the next item, taken only when idle, runs.
// asynchronous active-low reset: channels idle, swipe window closed, ring empty.
`timescale 1ns / 1ps

module touch_gesture_recognizer_unit #(
    parameter int CHANNELS   = 8,
    parameter int RING_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]     cfg_data,
    tgr_in_if.sink                             in_ch,
    tgr_out_if.source                          out_ch
);

    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_READ,
        ST_DONE
    } top_state_t;

    top_state_t                         state_reg;
    tgr_pkg::cfg_t                      cfg_reg;
    logic                               res_valid_reg;
    tgr_pkg::event_kind_t               res_kind_reg;
    logic [tgr_pkg::OUT_CHAN_W-1:0]     res_chan_reg;
    logic                               out_valid_reg;
    logic                               out_event_valid_reg;
    logic [tgr_pkg::KIND_W-1:0]         out_kind_reg;
    logic [tgr_pkg::OUT_CHAN_W-1:0]     out_chan_reg;
    logic [tgr_pkg::PEND_W-1:0]         out_pend_reg;

    logic                               accept;
    logic                               scan_start;
    logic                               scan_done;
    tgr_pkg::push_t                     push;
    logic                               pop;
    tgr_pkg::ring_entry_t               rd_data;
    logic [CNT_W-1:0]                   count;
    logic [CNT_W+2:0]                   count_wide;
    logic                               out_free;

    assign accept     = in_ch.valid && in_ch.ready;
    assign scan_start = accept && (in_ch.operation == tgr_pkg::OP_TICK);
    assign pop        = (state_reg == ST_READ);
    assign count_wide = (CNT_W + 3)'(count);
    assign out_free   = !out_valid_reg || out_ch.ready;

    tgr_scan #(
        .CHANNELS (CHANNELS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .mask  (in_ch.touch_mask),
        .cfg   (cfg_reg),
        .push  (push),
        .done  (scan_done)
    );

    tgr_ring #(
        .RING_DEPTH (RING_DEPTH),
        .CNT_W      (CNT_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .rd_data (rd_data),
        .count   (count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_min  <= tgr_pkg::HOLD_MIN_RESET;
            cfg_reg.tap_max   <= tgr_pkg::TAP_MAX_RESET;
            cfg_reg.swipe_max <= tgr_pkg::SWIPE_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgr_pkg::CFG_HOLD_MIN:  cfg_reg.hold_min  <= cfg_data;
                tgr_pkg::CFG_TAP_MAX:   cfg_reg.tap_max   <= cfg_data;
                tgr_pkg::CFG_SWIPE_MAX: cfg_reg.swipe_max <= cfg_data;
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            res_valid_reg       <= 1'b0;
            res_kind_reg        <= tgr_pkg::EV_NONE;
            res_chan_reg        <= '0;
            out_valid_reg       <= 1'b0;
            out_event_valid_reg <= 1'b0;
            out_kind_reg        <= '0;
            out_chan_reg        <= '0;
            out_pend_reg        <= '0;
        end
        else
        begin
            // the done state reloads the output register itself
            if (out_ch.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_valid_reg <= 1'b0;
                        res_kind_reg  <= tgr_pkg::EV_NONE;
                        res_chan_reg  <= '0;
                        state_reg     <= (in_ch.operation == tgr_pkg::OP_READ) ? ST_READ
                                                                               : ST_TICK;
                    end
                end
                ST_TICK:
                begin
                    if (scan_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_READ:
                begin
                    // ring pops in this cycle when not empty
                    if (count != '0)
                    begin
                        res_valid_reg <= 1'b1;
                        res_kind_reg  <= rd_data.kind;
                        res_chan_reg  <= rd_data.chan;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_event_valid_reg <= res_valid_reg;
                        out_kind_reg        <= res_kind_reg;
                        out_chan_reg        <= res_chan_reg;
                        out_pend_reg        <= count_wide[tgr_pkg::PEND_W-1:0];
                        state_reg           <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready           = (state_reg == ST_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.event_valid    = out_event_valid_reg;
    assign out_ch.event_kind     = out_kind_reg;
    assign out_ch.event_channel  = out_chan_reg;
    assign out_ch.pending_events = out_pend_reg;

endmodule

### design/tgr_checker.sv
// port-level checker for the touch gesture recognizer, bound to the top level
`timescale 1ns / 1ps
`include "touch_gesture_recognizer_unit_assert.svh"

module tgr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             event_valid,
    input logic [tgr_pkg::KIND_W-1:0]       event_kind,
    input logic [tgr_pkg::OUT_CHAN_W-1:0]   event_channel,
    input logic [tgr_pkg::PEND_W-1:0]       pending_events
);

    // a stalled result holds
    `TGR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(event_valid) && $stable(event_kind) && $stable(event_channel) && $stable(pending_events))

    // one transaction at a time: busy right after acceptance
    `TGR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // results with no event carry kind none and channel zero
    `TGR_ASSERT_IMPL(a_no_event_clean, clk, rst_n, out_valid && !event_valid, (event_kind == tgr_pkg::EV_NONE) && (event_channel == '0))

    // a returned event has a real kind
    `TGR_ASSERT_IMPL(a_event_kind, clk, rst_n, out_valid && event_valid, (event_kind != tgr_pkg::EV_NONE) && (event_kind <= tgr_pkg::EV_SWIPE_LEFT))

endmodule

bind touch_gesture_recognizer_unit tgr_checker u_tgr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .event_valid    (out_ch.event_valid),
    .event_kind     (out_ch.event_kind),
    .event_channel  (out_ch.event_channel),
    .pending_events (out_ch.pending_events)
);
